FILE: rtl/led_status_power_button_sequencer_defines.svh
// Assertion macros shared by the LED status and power-button sequencer RTL.
`ifndef LED_STATUS_POWER_BUTTON_SEQUENCER_DEFINES_SVH
`define LED_STATUS_POWER_BUTTON_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

`define LSPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define LSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LSPS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LSPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/lsps_pkg.sv
// Types and constants shared by the LED status and power-button sequencer.
package lsps_pkg;

  localparam logic [2:0] ST_UNKNOWN  = 3'd0;
  localparam logic [2:0] ST_OFF      = 3'd1;
  localparam logic [2:0] ST_STARTING = 3'd2;
  localparam logic [2:0] ST_ON       = 3'd3;
  localparam logic [2:0] ST_STOPPING = 3'd4;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_FINAL = 3'd3;
  localparam logic [2:0] PH_HOLD  = 3'd4;

  localparam logic [2:0] REG_LIT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PRESS_TICKS   = 3'd1;
  localparam logic [2:0] REG_GAP_TICKS     = 3'd2;
  localparam logic [2:0] REG_HOLDOFF_TICKS = 3'd3;

  localparam logic [11:0] LIT_THRESHOLD_RESET = 12'd1000;
  localparam logic [9:0]  PRESS_TICKS_RESET   = 10'd2;
  localparam logic [9:0]  GAP_TICKS_RESET     = 10'd30;
  localparam logic [9:0]  HOLDOFF_TICKS_RESET = 10'd100;

  typedef struct packed {
    logic filled;
    logic red;
    logic blue;
  } flags_t;

  typedef struct packed {
    logic full;
    logic all_blue;
    logic all_red;
    logic any_blue;
    logic any_red;
  } window_sum_t;

  typedef struct packed {
    logic [9:0] press;
    logic [9:0] gap;
    logic [9:0] holdoff;
  } timing_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       button_drive;
    logic [2:0] pending_request;
    logic [2:0] device_state;
  } result_t;

endpackage

FILE: rtl/lsps_cell.sv
// One window cell: holds the lit flags of one past tick and passes them on.
module lsps_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  lsps_pkg::flags_t d,
  output lsps_pkg::flags_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/lsps_seq.sv
// Device state inference and the timed power-button sequencer.
`include "led_status_power_button_sequencer_defines.svh"

module lsps_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  is_set,
  input  logic [2:0]            wanted_state,
  input  lsps_pkg::window_sum_t win,
  input  lsps_pkg::timing_t     timing,
  output lsps_pkg::result_t     result
);

  logic [2:0] observed;
  logic [2:0] request;
  logic [2:0] phase;
  logic [9:0] timer;
  logic       button;

  logic [2:0] observed_next;
  logic [2:0] request_next;
  logic [2:0] phase_next;
  logic [9:0] timer_next;
  logic       button_next;
  logic [2:0] inferred;

  always_comb begin
    inferred = lsps_pkg::ST_UNKNOWN;
    if (win.full) begin
      if (win.all_blue) begin
        inferred = lsps_pkg::ST_ON;
      end else if (win.all_red) begin
        inferred = lsps_pkg::ST_OFF;
      end else if (win.any_blue && win.any_red) begin
        inferred = lsps_pkg::ST_UNKNOWN;
      end else if (win.any_blue) begin
        inferred = lsps_pkg::ST_STARTING;
      end else if (win.any_red) begin
        inferred = lsps_pkg::ST_STOPPING;
      end
    end
  end

  always_comb begin
    observed_next = observed;
    request_next  = request;
    phase_next    = phase;
    timer_next    = timer;
    button_next   = button;
    if (is_set) begin
      request_next = (wanted_state > lsps_pkg::ST_STOPPING) ? lsps_pkg::ST_UNKNOWN
                                                           : wanted_state;
    end else begin
      observed_next = inferred;
      if (phase == lsps_pkg::PH_IDLE) begin
        if (inferred == lsps_pkg::ST_OFF) begin
          if (request == lsps_pkg::ST_ON) begin
            button_next = 1'b1;
            timer_next  = timing.press;
            phase_next  = lsps_pkg::PH_FINAL;
          end else if (request == lsps_pkg::ST_OFF) begin
            request_next = lsps_pkg::ST_UNKNOWN;
          end
        end else if (inferred == lsps_pkg::ST_ON) begin
          if (request == lsps_pkg::ST_OFF) begin
            button_next = 1'b1;
            timer_next  = timing.press;
            phase_next  = lsps_pkg::PH_FIRST;
          end else if (request == lsps_pkg::ST_ON) begin
            request_next = lsps_pkg::ST_UNKNOWN;
          end
        end
      end else if (timer != 10'd0) begin
        timer_next = timer - 10'd1;
      end else begin
        case (phase)
          lsps_pkg::PH_FIRST: begin
            button_next = 1'b0;
            timer_next  = timing.gap;
            phase_next  = lsps_pkg::PH_GAP;
          end
          lsps_pkg::PH_GAP: begin
            button_next = 1'b1;
            timer_next  = timing.press;
            phase_next  = lsps_pkg::PH_FINAL;
          end
          lsps_pkg::PH_FINAL: begin
            button_next = 1'b0;
            timer_next  = timing.holdoff;
            phase_next  = lsps_pkg::PH_HOLD;
          end
          default: begin
            phase_next   = lsps_pkg::PH_IDLE;
            request_next = lsps_pkg::ST_UNKNOWN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      observed <= lsps_pkg::ST_UNKNOWN;
      request  <= lsps_pkg::ST_UNKNOWN;
      phase    <= lsps_pkg::PH_IDLE;
      timer    <= '0;
      button   <= 1'b0;
    end else if (fire) begin
      observed <= observed_next;
      request  <= request_next;
      phase    <= phase_next;
      timer    <= timer_next;
      button   <= button_next;
    end
  end

  assign result.phase           = phase_next;
  assign result.button_drive    = button_next;
  assign result.pending_request = request_next;
  assign result.device_state    = observed_next;

  `LSPS_ASSERT_IMPLIES(a_button_in_press, clk, rst, button,
                       (phase == lsps_pkg::PH_FIRST) || (phase == lsps_pkg::PH_FINAL))
  `LSPS_ASSERT_IMPLIES(a_idle_quiet, clk, rst, phase == lsps_pkg::PH_IDLE,
                       (timer == 10'd0) && !button)

endmodule

FILE: rtl/lsps_outbuf.sv
// Two-entry output buffer that decouples input acceptance from result backpressure.
`include "led_status_power_button_sequencer_defines.svh"

module lsps_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsps_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lsps_pkg::result_t out_data
);

  logic              skid_valid;
  lsps_pkg::result_t skid_data;
  logic              in_fire;
  logic              out_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_fire) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= in_fire;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= in_data;
      end
    end else if (!out_valid) begin
      if (in_fire) begin
        out_data <= in_data;
      end
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

  `LSPS_ASSERT_IMPLIES(a_skid_has_head, clk, rst, skid_valid, out_valid)
  `LSPS_ASSERT_NEXT(a_skid_catches, clk, rst, in_fire && out_valid && !out_ready, skid_valid)

endmodule

FILE: rtl/led_status_power_button_sequencer.sv
// Top level of the LED status monitor and power-button sequencer.
// One beat is accepted per clock cycle while the output buffer has room, and
// its result beat is registered in that buffer; the two-entry buffer accepts
// one more input beat while the output is stalled. The lit flags of the last
// WINDOW ticks are the incoming flags plus a row of WINDOW-1 cells that shift
// on every tick, and the state inference and button sequencer settle in the
// same cycle.
module led_status_power_button_sequencer #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red_level[11:0], blue_level[23:12], wanted_state[26:24]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // device_state[2:0], pending_request[5:3],
                                 // button_drive[6], phase[9:7]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [11:0]           lit_threshold;
  lsps_pkg::timing_t     timing;
  logic                  fire;
  logic                  tick;
  lsps_pkg::flags_t      new_flags;
  lsps_pkg::flags_t      chain [WINDOW];
  lsps_pkg::window_sum_t win;
  lsps_pkg::result_t     result;
  lsps_pkg::result_t     out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_threshold  <= lsps_pkg::LIT_THRESHOLD_RESET;
      timing.press   <= lsps_pkg::PRESS_TICKS_RESET;
      timing.gap     <= lsps_pkg::GAP_TICKS_RESET;
      timing.holdoff <= lsps_pkg::HOLDOFF_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lsps_pkg::REG_LIT_THRESHOLD: lit_threshold  <= cfg_data;
        lsps_pkg::REG_PRESS_TICKS:   timing.press   <= cfg_data[9:0];
        lsps_pkg::REG_GAP_TICKS:     timing.gap     <= cfg_data[9:0];
        lsps_pkg::REG_HOLDOFF_TICKS: timing.holdoff <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign fire = s_tvalid && s_tready;
  assign tick = fire && !s_tuser;

  assign new_flags.filled = 1'b1;
  assign new_flags.red    = s_tdata[11:0] < lit_threshold;
  assign new_flags.blue   = s_tdata[23:12] < lit_threshold;

  assign chain[0] = new_flags;

  for (genvar i = 1; i < WINDOW; i++) begin : g_cell
    lsps_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (tick),
      .d     (chain[i-1]),
      .q     (chain[i])
    );
  end

  always_comb begin
    win.full     = chain[WINDOW-1].filled;
    win.all_blue = 1'b1;
    win.all_red  = 1'b1;
    win.any_blue = 1'b0;
    win.any_red  = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      win.all_blue = win.all_blue & chain[i].blue;
      win.all_red  = win.all_red & chain[i].red;
      win.any_blue = win.any_blue | chain[i].blue;
      win.any_red  = win.any_red | chain[i].red;
    end
  end

  lsps_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .is_set       (s_tuser),
    .wanted_state (s_tdata[26:24]),
    .win          (win),
    .timing       (timing),
    .result       (result)
  );

  lsps_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {6'd0, out_result};

endmodule

FILE: bench/tb_led_status_power_button_sequencer.sv
// Testbench for the LED status monitor and power-button sequencer, with a predictor and stream checker.
`timescale 1ns / 1ps

module tb_led_status_power_button_sequencer;
  import lsps_pkg::*;

  localparam int WIN = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam bit KIND_TICK = 1'b0;
  localparam bit KIND_SET = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  bit idle_en = 1'b1;
  bit stall_en = 1'b1;
  int errors = 0;
  int quiet_cycles = 0;
  result_t status_due[$];

  // Predicted block state and configuration.
  bit [WIN-1:0] red_lit_win;
  bit [WIN-1:0] blue_lit_win;
  int fill_cnt;
  logic [2:0] dev_state;
  logic [2:0] pending;
  logic [2:0] phase;
  logic [9:0] timer;
  logic button;
  logic [11:0] thr_q;
  logic [9:0] press_q;
  logic [9:0] gap_q;
  logic [9:0] hold_q;

  led_status_power_button_sequencer #(.WINDOW(WIN)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !stall_en || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void check_field(input string name, input logic [2:0] exp_v,
                                      input logic [2:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_status
    result_t exp_r;
    result_t got_r;
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) begin
        $error("result beat with no expected status");
        errors++;
      end else begin
        exp_r = status_due.pop_front();
        got_r = result_t'(m_tdata[9:0]);
        check_field("device_state", exp_r.device_state, got_r.device_state);
        check_field("pending_request", exp_r.pending_request, got_r.pending_request);
        check_field("button_drive", 3'(exp_r.button_drive), 3'(got_r.button_drive));
        check_field("phase", exp_r.phase, got_r.phase);
      end
    end
  end

  function automatic logic [2:0] infer_state();
    if (fill_cnt < WIN) return ST_UNKNOWN;
    if (&blue_lit_win) return ST_ON;
    if (&red_lit_win) return ST_OFF;
    if (|blue_lit_win && |red_lit_win) return ST_UNKNOWN;
    if (|blue_lit_win) return ST_STARTING;
    if (|red_lit_win) return ST_STOPPING;
    return ST_UNKNOWN;
  endfunction

  task automatic advance_status(input bit kind, input logic [11:0] red, input logic [11:0] blue,
                                input logic [2:0] want);
    result_t res;
    if (kind == KIND_SET) begin
      pending = (want > ST_STOPPING) ? ST_UNKNOWN : want;
    end else begin
      red_lit_win = {red_lit_win[WIN-2:0], red < thr_q};
      blue_lit_win = {blue_lit_win[WIN-2:0], blue < thr_q};
      if (fill_cnt < WIN) fill_cnt++;
      dev_state = infer_state();
      if (phase == PH_IDLE) begin
        if (dev_state == ST_OFF && pending == ST_ON) begin
          button = 1'b1;
          timer = press_q;
          phase = PH_FINAL;
        end else if (dev_state == ST_ON && pending == ST_OFF) begin
          button = 1'b1;
          timer = press_q;
          phase = PH_FIRST;
        end else if ((dev_state == ST_OFF || dev_state == ST_ON) && pending == dev_state) begin
          pending = ST_UNKNOWN;
        end
      end else if (timer != 0) begin
        timer--;
      end else begin
        case (phase)
          PH_FIRST: begin
            button = 1'b0;
            timer = gap_q;
            phase = PH_GAP;
          end
          PH_GAP: begin
            button = 1'b1;
            timer = press_q;
            phase = PH_FINAL;
          end
          PH_FINAL: begin
            button = 1'b0;
            timer = hold_q;
            phase = PH_HOLD;
          end
          default: begin
            phase = PH_IDLE;
            pending = ST_UNKNOWN;
          end
        endcase
      end
    end
    res.device_state = dev_state;
    res.pending_request = pending;
    res.button_drive = button;
    res.phase = phase;
    status_due.push_back(res);
  endtask

  task automatic send_beat(input bit kind, input logic [11:0] red, input logic [11:0] blue,
                           input logic [2:0] want);
    while (idle_en && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'd0, want, blue, red};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_status(kind, red, blue, want);
  endtask

  function automatic logic [11:0] level_for(input bit lit);
    int thr;
    thr = int'(thr_q);
    if (lit && thr > 0) begin
      if ($urandom_range(0, 7) == 0) return 12'(thr - 1);
      return 12'($urandom_range(0, thr - 1));
    end else if (!lit) begin
      if ($urandom_range(0, 7) == 0) return 12'(thr);
      return 12'($urandom_range(thr, 4095));
    end
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic send_tick(input bit red_lit, input bit blue_lit);
    send_beat(KIND_TICK, level_for(red_lit), level_for(blue_lit), 3'($urandom_range(0, 7)));
  endtask

  task automatic send_set(input logic [2:0] want);
    send_beat(KIND_SET, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), want);
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LIT_THRESHOLD: thr_q = value;
      REG_PRESS_TICKS: press_q = value[9:0];
      REG_GAP_TICKS: gap_q = value[9:0];
      REG_HOLDOFF_TICKS: hold_q = value[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] thr, input logic [11:0] press,
                           input logic [11:0] gap, input logic [11:0] hold);
    wait_results_done();
    write_reg(REG_LIT_THRESHOLD, thr);
    write_reg(REG_PRESS_TICKS, press);
    write_reg(REG_GAP_TICKS, gap);
    write_reg(REG_HOLDOFF_TICKS, hold);
  endtask

  function automatic logic [2:0] pick_request(input bit now_on);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return now_on ? ST_OFF : ST_ON;
    if (r < 8) return now_on ? ST_ON : ST_OFF;
    return 3'($urandom_range(0, 7));
  endfunction

  // Mostly steady LED patterns with a power request, plus partial runs and mixed noise runs.
  task automatic run_scenarios(input int n_items);
    int sent;
    int kind;
    int len;
    bit on_side;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(10, 24);
      on_side = $urandom_range(0, 1);
      if (kind < 6) begin
        send_set(pick_request(on_side));
        sent++;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 29) == 0) send_set(3'($urandom_range(0, 7)));
          else send_tick(!on_side, on_side);
          sent++;
        end
      end else if (kind < 8) begin
        for (int i = 0; i < len; i++) begin
          send_tick(!on_side && $urandom_range(0, 1), on_side && $urandom_range(0, 1));
          sent++;
        end
      end else begin
        for (int i = 0; i < len; i++) begin
          send_beat($urandom_range(0, 3) == 0, 12'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
          sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) wait_results_done();
    end
  endtask

  task automatic test_request_codes();
    for (int w = 0; w < 8; w++) send_set(3'(w));
    send_beat(KIND_TICK, 12'd0, 12'd0, 3'd7);
    send_beat(KIND_TICK, 12'd4095, 12'd4095, 3'd0);
    send_beat(KIND_TICK, 12'd0, 12'd4095, 3'd5);
    send_beat(KIND_TICK, 12'd4095, 12'd0, 3'd2);
    send_beat(KIND_TICK, 12'd999, 12'd1000, 3'd1);
    send_beat(KIND_TICK, 12'd1000, 12'd999, 3'd6);
    send_set(ST_ON);
    for (int i = 0; i < 4; i++) send_tick(1'b1, 1'b0);
  endtask

  task automatic test_power_sequences();
    configure(12'd2048, 12'd0, 12'd0, 12'd0);
    run_scenarios(80);
    configure(12'($urandom_range(200, 3000)), 12'($urandom_range(0, 3)),
              12'($urandom_range(0, 5)), 12'($urandom_range(0, 4)));
    run_scenarios(90);
  endtask

  task automatic test_no_idle();
    configure(12'($urandom_range(1, 4094)), 12'($urandom_range(0, 2)),
              12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)));
    idle_en = 1'b0;
    stall_en = 1'b0;
    run_scenarios(90);
    idle_en = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_threshold_extremes();
    configure(12'd0, 12'd1, 12'd1, 12'd1);
    run_scenarios(30);
    configure(12'd4095, 12'd0, 12'd2, 12'd1);
    run_scenarios(50);
  endtask

  task automatic test_register_masking();
    wait_results_done();
    write_reg(3'($urandom_range(4, 7)), 12'($urandom_range(0, 4095)));
    configure(12'($urandom_range(0, 4095)), 12'($urandom_range(1024, 4095)),
              12'($urandom_range(1024, 4095)), 12'($urandom_range(1024, 4095)));
    configure(12'd1000, 12'h400 | 12'($urandom_range(0, 2)), 12'h800 | 12'($urandom_range(0, 2)),
              12'hC00 | 12'($urandom_range(0, 2)));
    run_scenarios(50);
  endtask

  task automatic test_long_timings();
    configure(12'($urandom_range(200, 3000)), 12'd1023, 12'd1023, 12'd1023);
    send_set(ST_OFF);
    for (int i = 0; i < 40; i++) send_tick(1'b0, 1'b1);
  endtask

  initial begin
    thr_q = LIT_THRESHOLD_RESET;
    press_q = PRESS_TICKS_RESET;
    gap_q = GAP_TICKS_RESET;
    hold_q = HOLDOFF_TICKS_RESET;
    red_lit_win = '0;
    blue_lit_win = '0;
    fill_cnt = 0;
    dev_state = ST_UNKNOWN;
    pending = ST_UNKNOWN;
    phase = PH_IDLE;
    timer = '0;
    button = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_request_codes();
    test_power_sequences();
    test_no_idle();
    test_threshold_extremes();
    test_register_masking();
    test_long_timings();

    wait_results_done();
    repeat (10) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d expected status beats never arrived", status_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lsps_pkg.sv
rtl/lsps_cell.sv
rtl/lsps_seq.sv
rtl/lsps_outbuf.sv
rtl/led_status_power_button_sequencer.sv
bench/tb_led_status_power_button_sequencer.sv
